/* rtl/sto_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the sphere/triangle overlap pipeline.
// No dependencies; imported by sto_mul, sto_div and the top module.
package sto_pkg;

    // Digit width of the partial-product multiplier
    localparam int MUL_DIG = 32;

    // Closest-feature codes reported on the region port
    typedef enum logic [2:0] {
        REG_A    = 3'd0,
        REG_B    = 3'd1,
        REG_AB   = 3'd2,
        REG_C    = 3'd3,
        REG_CA   = 3'd4,
        REG_BC   = 3'd5,
        REG_FACE = 3'd6
    } region_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_CENTER_Z = 2'd2,
        CFG_RADIUS   = 2'd3
    } cfg_idx_t;

    // Control carried from the region decision to the point stage
    typedef struct packed {
        logic    use_div;
        region_t region;
    } dec_ctl_t;

    // Divider side flags
    typedef struct packed {
        logic ovf;
        logic neg;
    } div_flag_t;

    // Latency of sto_mul for given operand widths
    function automatic int mul_lat(input int wa, input int wb);
        return ((wa + MUL_DIG - 1) / MUL_DIG) * ((wb + MUL_DIG - 1) / MUL_DIG) + 2;
    endfunction

endpackage

/* rtl/sto_dly.sv */
`timescale 1ns / 1ps
// Fixed-depth register delay line for side data that rides along the pipeline.
// No package dependencies.
module sto_dly #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    // Shift chain
    always_ff @(posedge clk)
    begin
        tap_reg[0] <= d;
        for (int i = 1; i < DEPTH; i++)
        begin
            tap_reg[i] <= tap_reg[i-1];
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

/* rtl/sto_mul.sv */
`timescale 1ns / 1ps
// Pipelined signed multiplier: one MUL_DIG x MUL_DIG partial product per stage.
// Depends on sto_pkg (MUL_DIG).
module sto_mul
    import sto_pkg::*;
#(
    parameter int WA = 33,
    parameter int WB = 33
) (
    input  logic                    clk,
    input  logic signed [WA-1:0]    a,
    input  logic signed [WB-1:0]    b,
    output logic signed [WA+WB-1:0] p
);

    localparam int NA   = (WA + MUL_DIG - 1) / MUL_DIG;
    localparam int NB   = (WB + MUL_DIG - 1) / MUL_DIG;
    localparam int NS   = NA * NB;
    localparam int AW   = NA * MUL_DIG;
    localparam int BW   = NB * MUL_DIG;
    localparam int ACCW = AW + BW;
    localparam int PW   = WA + WB;

    logic [WA-1:0]   a_abs;
    logic [WB-1:0]   b_abs;
    logic [AW-1:0]   ma_reg  [NS];
    logic [BW-1:0]   mb_reg  [NS];
    logic            neg_reg [NS+1];
    logic [ACCW-1:0] acc_reg [NS+1];
    logic [ACCW-1:0] acc_neg;

    // Sign and magnitude split
    assign a_abs = a[WA-1] ? WA'(~a + WA'(1)) : WA'(a);
    assign b_abs = b[WB-1] ? WB'(~b + WB'(1)) : WB'(b);

    always_ff @(posedge clk)
    begin
        ma_reg[0]  <= AW'(a_abs);
        mb_reg[0]  <= BW'(b_abs);
        neg_reg[0] <= a[WA-1] ^ b[WB-1];
        acc_reg[0] <= '0;
    end

    // One digit product accumulated per stage
    for (genvar s = 0; s < NS; s++)
    begin : g_pp
        localparam int I = s / NB;
        localparam int J = s % NB;
        logic [2*MUL_DIG-1:0] pp;

        assign pp = ma_reg[s][I*MUL_DIG +: MUL_DIG] * mb_reg[s][J*MUL_DIG +: MUL_DIG];

        always_ff @(posedge clk)
        begin
            acc_reg[s+1] <= acc_reg[s] + (ACCW'(pp) << (MUL_DIG * (I + J)));
            neg_reg[s+1] <= neg_reg[s];
        end

        if (s < NS - 1)
        begin : g_fwd
            always_ff @(posedge clk)
            begin
                ma_reg[s+1] <= ma_reg[s];
                mb_reg[s+1] <= mb_reg[s];
            end
        end
    end

    // Restore sign
    assign acc_neg = ~acc_reg[NS] + ACCW'(1);

    always_ff @(posedge clk)
    begin
        p <= PW'(neg_reg[NS] ? acc_neg : acc_reg[NS]);
    end

endmodule

/* rtl/sto_div.sv */
`timescale 1ns / 1ps
// Pipelined signed divider, truncating toward zero, one quotient bit per stage.
// Depends on sto_pkg (div_flag_t). Flags a quotient of 2^QB or more.
module sto_div
    import sto_pkg::*;
#(
    parameter int WN = 64,
    parameter int WD = 32,
    parameter int QB = 33
) (
    input  logic                 clk,
    input  logic signed [WN-1:0] num,
    input  logic signed [WD-1:0] den,
    output logic signed [QB:0]   q,
    output div_flag_t            flg
);

    logic [WN-1:0] n_abs;
    logic [WD-1:0] d_abs;
    logic [WN-1:0] n_hi;
    logic [WD-1:0] rem_reg [QB];
    logic [QB-1:0] low_reg [QB];
    logic [WD-1:0] md_reg  [QB];
    logic [QB-1:0] q_reg   [QB+1];
    logic          neg_reg [QB+1];
    logic          ovf_reg [QB+1];
    logic [QB:0]   q_ext;

    // Magnitudes and overflow check
    assign n_abs = num[WN-1] ? WN'(~num + WN'(1)) : WN'(num);
    assign d_abs = den[WD-1] ? WD'(~den + WD'(1)) : WD'(den);
    assign n_hi  = n_abs >> QB;

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= WD'(n_hi);
        low_reg[0] <= n_abs[QB-1:0];
        md_reg[0]  <= d_abs;
        q_reg[0]   <= '0;
        neg_reg[0] <= num[WN-1] ^ den[WD-1];
        ovf_reg[0] <= (n_hi >= WN'(d_abs));
    end

    // Restoring steps, MSB first
    for (genvar s = 0; s < QB; s++)
    begin : g_step
        logic [WD:0] trial;
        logic        ge;

        assign trial = {rem_reg[s], low_reg[s][QB-1]};
        assign ge    = (trial >= {1'b0, md_reg[s]});

        always_ff @(posedge clk)
        begin
            q_reg[s+1]   <= {q_reg[s][QB-2:0], ge};
            neg_reg[s+1] <= neg_reg[s];
            ovf_reg[s+1] <= ovf_reg[s];
        end

        if (s < QB - 1)
        begin : g_fwd
            always_ff @(posedge clk)
            begin
                rem_reg[s+1] <= ge ? WD'(trial - {1'b0, md_reg[s]}) : WD'(trial);
                low_reg[s+1] <= {low_reg[s][QB-2:0], 1'b0};
                md_reg[s+1]  <= md_reg[s];
            end
        end
    end

    // Apply sign
    assign q_ext = {1'b0, q_reg[QB]};

    always_ff @(posedge clk)
    begin
        q   <= neg_reg[QB] ? -q_ext : q_ext;
        flg <= '{ovf: ovf_reg[QB], neg: neg_reg[QB]};
    end

endmodule

/* rtl/sphere_triangle_overlap_test.sv */
`timescale 1ns / 1ps
// Sphere versus triangle overlap test: closest point on triangle, region, hit.
// Depends on sto_pkg, sto_mul, sto_div, sto_dly.
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+-----------------------------------
//  request   | start in, busy out          | a_x..c_z (three vertices)
//  result    | done out (one-cycle strobe) | hit, near_x/y/z, region
//  config    | cfg_valid in, cfg_ready out | cfg_index, cfg_data
//
// One request per cycle; busy is always low. The divider, one quotient bit per
// stage, and the partial-product multipliers set the depth of the pipeline.
// rst_n clears the valid chain and the configuration registers; the receiver
// cannot stall.
module sphere_triangle_overlap_test
    import sto_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] a_x,
    input  logic signed [COORD_WIDTH-1:0] a_y,
    input  logic signed [COORD_WIDTH-1:0] a_z,
    input  logic signed [COORD_WIDTH-1:0] b_x,
    input  logic signed [COORD_WIDTH-1:0] b_y,
    input  logic signed [COORD_WIDTH-1:0] b_z,
    input  logic signed [COORD_WIDTH-1:0] c_x,
    input  logic signed [COORD_WIDTH-1:0] c_y,
    input  logic signed [COORD_WIDTH-1:0] c_z,
    output logic                          done,
    output logic                          hit,
    output logic signed [COORD_WIDTH-1:0] near_x,
    output logic signed [COORD_WIDTH-1:0] near_y,
    output logic signed [COORD_WIDTH-1:0] near_z,
    output logic [2:0]                    region,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [COORD_WIDTH-1:0]        cfg_data
);

    localparam int W     = COORD_WIDTH;
    localparam int DW    = W + 1;
    localparam int PW    = 2 * DW;
    localparam int DTW   = PW + 2;
    localparam int DNW   = DTW + 1;
    localparam int DEW   = DTW + 2;
    localparam int VW    = 2 * DTW + 1;
    localparam int SW    = VW + 2;
    localparam int FNW   = DW + VW + 1;
    localparam int QB    = W + 1;
    localparam int SUMW  = W + 3;
    localparam int DSW   = PW + 2;
    localparam int CTLW  = $bits(dec_ctl_t);
    localparam int L1    = mul_lat(DW, DW);
    localparam int L2    = mul_lat(DTW, DTW);
    localparam int L3    = mul_lat(DW, VW);
    localparam int L4    = QB + 2;
    localparam int X     = L1 + L2 + L3 + L4;
    localparam int TOTAL = 8 + X + L1;
    localparam int DEC_V = 3 + L1 + L2;
    localparam int PNT_V = 4 + X;

    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    // ---------------- configuration ----------------
    logic signed [W-1:0] pc_reg [3];
    logic [W-2:0]        r_reg;
    logic signed [2*W-1:0] rr_full;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg[0] <= '0;
            pc_reg[1] <= '0;
            pc_reg[2] <= '0;
            r_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CENTER_X: pc_reg[0] <= signed'(cfg_data);
                CFG_CENTER_Y: pc_reg[1] <= signed'(cfg_data);
                CFG_CENTER_Z: pc_reg[2] <= signed'(cfg_data);
                CFG_RADIUS:   r_reg     <= cfg_data[W-2:0];
            endcase
        end
    end

    // Squared radius, refreshed continuously
    sto_mul #(.WA(W), .WB(W)) u_rr (
        .clk (clk),
        .a   (signed'({1'b0, r_reg})),
        .b   (signed'({1'b0, r_reg})),
        .p   (rr_full)
    );

    // ---------------- valid chain ----------------
    logic [TOTAL-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[TOTAL-2:0], start && !busy};
    end

    assign done = vld_reg[TOTAL-1];

    // ---------------- stage 1: edge and center vectors ----------------
    logic signed [W-1:0]  in_a [3];
    logic signed [W-1:0]  in_b [3];
    logic signed [W-1:0]  in_c [3];
    logic signed [DW-1:0] ab_reg [3];
    logic signed [DW-1:0] ca_reg [3];
    logic signed [DW-1:0] bc_reg [3];
    logic signed [DW-1:0] ap_reg [3];
    logic signed [DW-1:0] bp_reg [3];
    logic signed [DW-1:0] cp_reg [3];

    assign in_a[0] = a_x;
    assign in_a[1] = a_y;
    assign in_a[2] = a_z;
    assign in_b[0] = b_x;
    assign in_b[1] = b_y;
    assign in_b[2] = b_z;
    assign in_c[0] = c_x;
    assign in_c[1] = c_y;
    assign in_c[2] = c_z;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            ab_reg[k] <= DW'(in_b[k]) - DW'(in_a[k]);
            ca_reg[k] <= DW'(in_a[k]) - DW'(in_c[k]);
            bc_reg[k] <= DW'(in_c[k]) - DW'(in_b[k]);
            ap_reg[k] <= DW'(pc_reg[k]) - DW'(in_a[k]);
            bp_reg[k] <= DW'(pc_reg[k]) - DW'(in_b[k]);
            cp_reg[k] <= DW'(pc_reg[k]) - DW'(in_c[k]);
        end
    end

    // Vertices ride alongside to the region decision
    logic [9*W-1:0] vtx_d;

    sto_dly #(.WIDTH(9*W), .DEPTH(DEC_V)) u_vtx_dly (
        .clk (clk),
        .d   ({c_z, c_y, c_x, b_z, b_y, b_x, a_z, a_y, a_x}),
        .q   (vtx_d)
    );

    // ---------------- dot products d1..d8 ----------------
    logic signed [DW-1:0]  dot_u [8][3];
    logic signed [DW-1:0]  dot_v [8][3];
    logic signed [PW-1:0]  dot_p [8][3];
    logic signed [DTW-1:0] d_reg [8];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dot_u[0][k] = ab_reg[k]; dot_v[0][k] = ap_reg[k];
            dot_u[1][k] = ca_reg[k]; dot_v[1][k] = ap_reg[k];
            dot_u[2][k] = ab_reg[k]; dot_v[2][k] = bp_reg[k];
            dot_u[3][k] = bc_reg[k]; dot_v[3][k] = bp_reg[k];
            dot_u[4][k] = ca_reg[k]; dot_v[4][k] = bp_reg[k];
            dot_u[5][k] = ca_reg[k]; dot_v[5][k] = cp_reg[k];
            dot_u[6][k] = bc_reg[k]; dot_v[6][k] = cp_reg[k];
            dot_u[7][k] = ab_reg[k]; dot_v[7][k] = cp_reg[k];
        end
    end

    for (genvar i = 0; i < 8; i++)
    begin : g_dot
        for (genvar k = 0; k < 3; k++)
        begin : g_ax
            sto_mul #(.WA(DW), .WB(DW)) u_mul (
                .clk (clk),
                .a   (dot_u[i][k]),
                .b   (dot_v[i][k]),
                .p   (dot_p[i][k])
            );
        end
    end

    // Dot sums
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 8; i++)
        begin
            d_reg[i] <= DTW'(dot_p[i][0]) + DTW'(dot_p[i][1]) + DTW'(dot_p[i][2]);
        end
    end

    // ---------------- barycentric terms va, vb, vc ----------------
    logic signed [DTW-1:0]   vm_a [6];
    logic signed [DTW-1:0]   vm_b [6];
    logic signed [2*DTW-1:0] vm_p [6];
    logic signed [VW-1:0]    vc_reg;
    logic signed [VW-1:0]    vb_reg;
    logic signed [VW-1:0]    va_reg;

    // d3*d2, d1*d5, d1*d6, d8*d2, d8*d5, d3*d6
    assign vm_a[0] = d_reg[2]; assign vm_b[0] = d_reg[1];
    assign vm_a[1] = d_reg[0]; assign vm_b[1] = d_reg[4];
    assign vm_a[2] = d_reg[0]; assign vm_b[2] = d_reg[5];
    assign vm_a[3] = d_reg[7]; assign vm_b[3] = d_reg[1];
    assign vm_a[4] = d_reg[7]; assign vm_b[4] = d_reg[4];
    assign vm_a[5] = d_reg[2]; assign vm_b[5] = d_reg[5];

    for (genvar i = 0; i < 6; i++)
    begin : g_vm
        sto_mul #(.WA(DTW), .WB(DTW)) u_mul (
            .clk (clk),
            .a   (vm_a[i]),
            .b   (vm_b[i]),
            .p   (vm_p[i])
        );
    end

    always_ff @(posedge clk)
    begin
        vc_reg <= VW'(vm_p[0]) - VW'(vm_p[1]);
        vb_reg <= VW'(vm_p[2]) - VW'(vm_p[3]);
        va_reg <= VW'(vm_p[4]) - VW'(vm_p[5]);
    end

    // Dot products delayed to meet va/vb/vc
    logic [8*DTW-1:0]      d_pk;
    logic [8*DTW-1:0]      d_pk_d;
    logic signed [DTW-1:0] dd [8];

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            d_pk[i*DTW +: DTW] = d_reg[i];
            dd[i] = signed'(d_pk_d[i*DTW +: DTW]);
        end
    end

    sto_dly #(.WIDTH(8*DTW), .DEPTH(1 + L2)) u_d_dly (
        .clk (clk),
        .d   (d_pk),
        .q   (d_pk_d)
    );

    // ---------------- region decision ----------------
    logic signed [W-1:0]   va_v [3];
    logic signed [W-1:0]   vb_v [3];
    logic signed [W-1:0]   vc_v [3];
    logic signed [DW-1:0]  e_ab [3];
    logic signed [DW-1:0]  e_ca [3];
    logic signed [DW-1:0]  e_bc [3];
    logic signed [DNW-1:0] n1;
    logic signed [DNW-1:0] n2;
    logic signed [SW-1:0]  s_sum;
    logic signed [DNW-1:0] den_ab;
    logic signed [DNW-1:0] den_ca;
    logic signed [DEW-1:0] den_bc;
    logic                  c_a, c_b, c_ab, c_c, c_ca, c_bc;

    dec_ctl_t              dec_ctl;
    logic signed [W-1:0]   dec_base [3];
    logic signed [DW-1:0]  dec_op1a [3];
    logic signed [DW-1:0]  dec_op2a [3];
    logic signed [VW-1:0]  dec_op1b;
    logic signed [VW-1:0]  dec_op2b;
    logic signed [SW-1:0]  dec_den;

    dec_ctl_t              dec_ctl_reg;
    logic signed [W-1:0]   base_reg [3];
    logic signed [DW-1:0]  op1a_reg [3];
    logic signed [DW-1:0]  op2a_reg [3];
    logic signed [VW-1:0]  op1b_reg;
    logic signed [VW-1:0]  op2b_reg;
    logic signed [SW-1:0]  den_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            va_v[k] = signed'(vtx_d[k*W +: W]);
            vb_v[k] = signed'(vtx_d[(3+k)*W +: W]);
            vc_v[k] = signed'(vtx_d[(6+k)*W +: W]);
            e_ab[k] = DW'(vb_v[k]) - DW'(va_v[k]);
            e_ca[k] = DW'(va_v[k]) - DW'(vc_v[k]);
            e_bc[k] = DW'(vc_v[k]) - DW'(vb_v[k]);
        end
    end

    // Edge and face weights
    assign n1     = -DNW'(dd[4]) - DNW'(dd[2]);
    assign n2     = DNW'(dd[7]) + DNW'(dd[5]);
    assign s_sum  = SW'(va_reg) + SW'(vb_reg) + SW'(vc_reg);
    assign den_ab = DNW'(dd[0]) - DNW'(dd[2]);
    assign den_ca = DNW'(dd[5]) - DNW'(dd[1]);
    assign den_bc = DEW'(n1) + DEW'(n2);

    // Voronoi tests (x <= 0 is sign or zero, x >= 0 is no sign)
    assign c_a  = (dd[0][DTW-1] || dd[0] == '0) && !dd[1][DTW-1];
    assign c_b  = !dd[2][DTW-1] && (dd[3][DTW-1] || dd[3] == '0);
    assign c_ab = (vc_reg[VW-1] || vc_reg == '0) && !dd[0][DTW-1]
                  && (dd[2][DTW-1] || dd[2] == '0);
    assign c_c  = (dd[5][DTW-1] || dd[5] == '0) && !dd[6][DTW-1];
    assign c_ca = (vb_reg[VW-1] || vb_reg == '0) && (dd[1][DTW-1] || dd[1] == '0)
                  && !dd[5][DTW-1];
    assign c_bc = (va_reg[VW-1] || va_reg == '0) && !n1[DNW-1] && !n2[DNW-1];

    always_comb
    begin
        dec_ctl.region  = REG_FACE;
        dec_ctl.use_div = 1'b0;
        dec_op1b        = '0;
        dec_op2b        = '0;
        dec_den         = '0;
        for (int k = 0; k < 3; k++)
        begin
            dec_base[k] = va_v[k];
            dec_op1a[k] = '0;
            dec_op2a[k] = '0;
        end
        priority if (c_a)
        begin
            dec_ctl.region = REG_A;
        end
        else if (c_b)
        begin
            dec_ctl.region = REG_B;
            dec_base       = vb_v;
        end
        else if (c_ab)
        begin
            dec_ctl.region  = REG_AB;
            dec_op1a        = e_ab;
            dec_op1b        = VW'(dd[0]);
            dec_den         = SW'(den_ab);
            dec_ctl.use_div = (den_ab != '0);
        end
        else if (c_c)
        begin
            dec_ctl.region = REG_C;
            dec_base       = vc_v;
        end
        else if (c_ca)
        begin
            dec_ctl.region  = REG_CA;
            dec_base        = vc_v;
            dec_op1a        = e_ca;
            dec_op1b        = VW'(dd[5]);
            dec_den         = SW'(den_ca);
            dec_ctl.use_div = (den_ca != '0);
        end
        else if (c_bc)
        begin
            dec_ctl.region  = REG_BC;
            dec_base        = vb_v;
            dec_op1a        = e_bc;
            dec_op1b        = VW'(n1);
            dec_den         = SW'(den_bc);
            dec_ctl.use_div = (den_bc != '0);
        end
        else
        begin
            // face: A + (ab*vb - ca*vc) / (va + vb + vc)
            dec_op1a        = e_ab;
            dec_op1b        = vb_reg;
            dec_op2a        = e_ca;
            dec_op2b        = vc_reg;
            dec_den         = s_sum;
            dec_ctl.use_div = (s_sum != '0);
        end
    end

    always_ff @(posedge clk)
    begin
        dec_ctl_reg <= dec_ctl;
        base_reg    <= dec_base;
        op1a_reg    <= dec_op1a;
        op2a_reg    <= dec_op2a;
        op1b_reg    <= dec_op1b;
        op2b_reg    <= dec_op2b;
        den_reg     <= dec_den;
    end

    // ---------------- weighted numerators ----------------
    logic signed [DW+VW-1:0] p1 [3];
    logic signed [DW+VW-1:0] p2 [3];
    logic signed [FNW-1:0]   num_reg [3];

    for (genvar k = 0; k < 3; k++)
    begin : g_num
        sto_mul #(.WA(DW), .WB(VW)) u_mul1 (
            .clk (clk),
            .a   (op1a_reg[k]),
            .b   (op1b_reg),
            .p   (p1[k])
        );
        sto_mul #(.WA(DW), .WB(VW)) u_mul2 (
            .clk (clk),
            .a   (op2a_reg[k]),
            .b   (op2b_reg),
            .p   (p2[k])
        );
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            num_reg[k] <= FNW'(p1[k]) - FNW'(p2[k]);
        end
    end

    // Denominator and point-stage control delayed to their consumers
    logic [SW-1:0]         den_d;
    logic [3*W+CTLW-1:0]   pnt_d;
    dec_ctl_t              pnt_ctl;
    logic signed [W-1:0]   pnt_base [3];

    sto_dly #(.WIDTH(SW), .DEPTH(L3 + 1)) u_den_dly (
        .clk (clk),
        .d   (den_reg),
        .q   (den_d)
    );

    sto_dly #(.WIDTH(3*W + CTLW), .DEPTH(L3 + 1 + L4)) u_pnt_dly (
        .clk (clk),
        .d   ({base_reg[2], base_reg[1], base_reg[0], dec_ctl_reg}),
        .q   (pnt_d)
    );

    assign pnt_ctl = dec_ctl_t'(pnt_d[CTLW-1:0]);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pnt_base[k] = signed'(pnt_d[CTLW + k*W +: W]);
        end
    end

    // ---------------- division ----------------
    logic signed [QB:0] quo [3];
    div_flag_t          flg [3];

    for (genvar k = 0; k < 3; k++)
    begin : g_div
        sto_div #(.WN(FNW), .WD(SW), .QB(QB)) u_div (
            .clk (clk),
            .num (num_reg[k]),
            .den (signed'(den_d)),
            .q   (quo[k]),
            .flg (flg[k])
        );
    end

    // ---------------- closest point with saturation ----------------
    logic signed [SUMW-1:0] pnt_sum [3];
    logic signed [W-1:0]    pnt_val [3];
    logic signed [W-1:0]    near_reg [3];
    region_t                near_region_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pnt_sum[k] = SUMW'(pnt_base[k]) + SUMW'(quo[k]);
            priority if (!pnt_ctl.use_div)
                pnt_val[k] = pnt_base[k];
            else if (flg[k].ovf)
                pnt_val[k] = flg[k].neg ? MINV : MAXV;
            else if (pnt_sum[k] > SUMW'(MAXV))
                pnt_val[k] = MAXV;
            else if (pnt_sum[k] < SUMW'(MINV))
                pnt_val[k] = MINV;
            else
                pnt_val[k] = W'(pnt_sum[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        near_reg        <= pnt_val;
        near_region_reg <= pnt_ctl.region;
    end

    // ---------------- squared distance ----------------
    logic signed [DW-1:0] dlt [3];
    logic signed [PW-1:0] sq  [3];
    logic [DSW-1:0]       dist_reg;

    for (genvar k = 0; k < 3; k++)
    begin : g_dist
        assign dlt[k] = DW'(pc_reg[k]) - DW'(near_reg[k]);

        sto_mul #(.WA(DW), .WB(DW)) u_mul (
            .clk (clk),
            .a   (dlt[k]),
            .b   (dlt[k]),
            .p   (sq[k])
        );
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= DSW'(DSW'(sq[0]) + DSW'(sq[1]) + DSW'(sq[2]));
    end

    // Point and region delayed to the output stage
    logic [3*W+2:0] out_d;

    sto_dly #(.WIDTH(3*W + 3), .DEPTH(L1 + 1)) u_out_dly (
        .clk (clk),
        .d   ({near_reg[2], near_reg[1], near_reg[0], near_region_reg}),
        .q   (out_d)
    );

    // ---------------- output register ----------------
    logic                hit_reg;
    logic signed [W-1:0] out_near_reg [3];
    logic [2:0]          out_region_reg;

    always_ff @(posedge clk)
    begin
        hit_reg        <= (dist_reg <= DSW'(unsigned'(rr_full)));
        out_region_reg <= out_d[2:0];
        for (int k = 0; k < 3; k++)
        begin
            out_near_reg[k] <= signed'(out_d[3 + k*W +: W]);
        end
    end

    assign hit    = hit_reg;
    assign near_x = out_near_reg[0];
    assign near_y = out_near_reg[1];
    assign near_z = out_near_reg[2];
    assign region = out_region_reg;

    // ---------------- assertions ----------------
    // every accepted request produces a done strobe at the end of the pipeline
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##TOTAL done)
        else $error("result strobe missing after request");

    // vertex regions never route through the divider
    a_vertex_nodiv: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[DEC_V] && (dec_ctl_reg.region == REG_A || dec_ctl_reg.region == REG_B
                            || dec_ctl_reg.region == REG_C)) |-> !dec_ctl_reg.use_div)
        else $error("vertex region flagged for division");

    // edge weights lie in [0,1], so an edge quotient never overflows
    a_edge_noovf: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[PNT_V] && pnt_ctl.use_div && (pnt_ctl.region == REG_AB
            || pnt_ctl.region == REG_CA || pnt_ctl.region == REG_BC))
        |-> !(flg[0].ovf || flg[1].ovf || flg[2].ovf))
        else $error("edge quotient overflow");

endmodule
